// ===== design/lhw_pkg.sv =====
// Package for the link health watchdog: link state encoding, per-link state
// record and configuration register indexes.
// No dependencies.
`default_nettype none

package lhw_pkg;

  typedef enum logic [2:0] {
    LS_UNKNOWN      = 3'd0,
    LS_CONNECTED    = 3'd1,
    LS_DEGRADED     = 3'd2,
    LS_DISCONNECTED = 3'd3,
    LS_STARTING     = 3'd4
  } link_state_t;

  typedef struct packed {
    link_state_t state;
    logic [15:0] dead;
    logic        latched;
    logic [1:0]  stable_run;
  } lhw_state_t;

  localparam lhw_state_t STATE_INIT = '{LS_UNKNOWN, 16'd0, 1'b0, 2'd0};

  localparam logic [15:0] DEAD_MAX = 16'hFFFF;
  localparam logic [1:0]  RUN_MAX  = 2'd3;

  localparam logic [1:0] CFG_MIN_INTERVAL   = 2'd0;
  localparam logic [1:0] CFG_MAX_INTERVAL   = 2'd1;
  localparam logic [1:0] CFG_REPAIR_LIMIT   = 2'd2;
  localparam logic [1:0] CFG_DROP_ALLOWANCE = 2'd3;

endpackage

`default_nettype wire

// ===== design/lhw_step.sv =====
// Per-probe update: classifies the link and computes the next dead counter,
// repair latch, stable run and probe interval. Purely combinational.
// Depends on lhw_pkg.
`default_nettype none

module lhw_step import lhw_pkg::*; #(
  parameter int INTERVAL_WIDTH = 32
) (
  input  wire lhw_state_t               st,
  input  wire [INTERVAL_WIDTH-1:0]      cur_interval,
  input  wire [INTERVAL_WIDTH-1:0]      min_interval,
  input  wire [INTERVAL_WIDTH-1:0]      max_interval,
  input  wire [15:0]                    repair_limit,
  input  wire [15:0]                    drop_allowance,
  input  wire                           process_alive,
  input  wire                           service_healthy,
  input  wire                           peer_connected,
  output lhw_state_t                    st_next,
  output logic [INTERVAL_WIDTH-1:0]     interval_next,
  output logic                          trig
);

  link_state_t             ns;
  logic [16:0]             inc;
  logic [16:0]             dead_raw;
  logic [1:0]              run_n;
  logic [1:0]              run_next;
  logic [INTERVAL_WIDTH:0] grown;

  always_comb begin
    if (process_alive && service_healthy) begin
      ns = peer_connected ? LS_CONNECTED : LS_DEGRADED;
    end else if (!process_alive) begin
      ns = LS_DISCONNECTED;
    end else begin
      ns = LS_STARTING;
    end
  end

  always_comb begin
    inc = {1'b0, st.dead} + 17'd1;
    if (ns == LS_CONNECTED || ns == LS_DEGRADED) begin
      dead_raw = 17'd0;
    end else if (st.state == LS_CONNECTED && ns == LS_DISCONNECTED) begin
      dead_raw = (inc <= {1'b0, drop_allowance}) ? 17'd0 : inc - {1'b0, drop_allowance};
    end else begin
      dead_raw = inc;
    end
  end

  always_comb begin
    st_next.state = ns;
    st_next.dead  = (dead_raw > {1'b0, DEAD_MAX}) ? DEAD_MAX : dead_raw[15:0];
    trig = (ns != LS_CONNECTED) && (st_next.dead >= repair_limit) && !st.latched;
    if (ns == LS_CONNECTED) begin
      st_next.latched = 1'b0;
    end else begin
      st_next.latched = st.latched | trig;
    end
    st_next.stable_run = run_next;
  end

  always_comb begin
    run_n = (st.stable_run == RUN_MAX) ? RUN_MAX : st.stable_run + 2'd1;
    grown = {1'b0, cur_interval} + {2'b00, cur_interval[INTERVAL_WIDTH-1:1]};
    if (ns == LS_CONNECTED) begin
      run_next = run_n;
      if (run_n == RUN_MAX) begin
        interval_next = (grown > {1'b0, max_interval}) ? max_interval
                                                       : grown[INTERVAL_WIDTH-1:0];
      end else begin
        interval_next = cur_interval;
      end
    end else begin
      run_next      = 2'd0;
      interval_next = min_interval;
    end
  end

endmodule

`default_nettype wire

// ===== design/link_health_watchdog.sv =====
// Link health watchdog top level: probe input register, state update and
// result register. Depends on lhw_pkg and lhw_step.
//
// Usage:
//   Probe words enter on in_valid/in_ready, carrying three health flags and
//   a 48-bit timestamp. Each probe yields exactly one result word on
//   out_valid/out_ready: link state, repair trigger, dead count, next probe
//   interval and the transition event fields.
//   A probe is captured in the input register at acceptance and moves into the
//   result register, which drives out_valid. One probe per cycle while out_ready
//   stays high; the per-link state is updated in one pass of short logic as a
//   probe moves into the result register, so the following probe sees it.
//   When the receiver stalls, the result register holds its word and the
//   input register fills; in_ready drops when both are full and out_ready is low.
//   Configuration: cfg_write with cfg_index and cfg_data writes one
//   register and reinitializes the link state. Write only
//   while no probe is in flight.
//   Reset (rst, synchronous) restores default registers (min 1000,
//   max 30000, repair limit 3, drop allowance 0), clears the link state and
//   empties both registers.
`default_nettype none

module link_health_watchdog import lhw_pkg::*; #(
  parameter int INTERVAL_WIDTH = 32
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_write,
  input  wire [1:0]                 cfg_index,
  input  wire [INTERVAL_WIDTH-1:0]  cfg_data,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire                       process_alive,
  input  wire                       service_healthy,
  input  wire                       peer_connected,
  input  wire [47:0]                probe_time,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic [2:0]                link_state,
  output logic                      repair_trigger,
  output logic [15:0]               dead_probes,
  output logic [INTERVAL_WIDTH-1:0] next_interval,
  output logic                      event_valid,
  output logic [2:0]                event_from,
  output logic [2:0]                event_to,
  output logic [47:0]               event_time
);

  logic [INTERVAL_WIDTH-1:0] min_interval;
  logic [INTERVAL_WIDTH-1:0] max_interval;
  logic [15:0]               repair_limit;
  logic [15:0]               drop_allowance;

  lhw_state_t                st;
  lhw_state_t                st_next;
  logic [INTERVAL_WIDTH-1:0] cur_interval;
  logic [INTERVAL_WIDTH-1:0] interval_next;
  logic                      trig;
  logic                      ev;

  logic        s1_valid;
  logic        s1_alive;
  logic        s1_healthy;
  logic        s1_peer;
  logic [47:0] s1_time;
  logic        s1_fire;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_alive   <= process_alive;
      s1_healthy <= service_healthy;
      s1_peer    <= peer_connected;
      s1_time    <= probe_time;
    end
  end

  lhw_step #(
    .INTERVAL_WIDTH(INTERVAL_WIDTH)
  ) u_step (
    .st              (st),
    .cur_interval    (cur_interval),
    .min_interval    (min_interval),
    .max_interval    (max_interval),
    .repair_limit    (repair_limit),
    .drop_allowance  (drop_allowance),
    .process_alive   (s1_alive),
    .service_healthy (s1_healthy),
    .peer_connected  (s1_peer),
    .st_next         (st_next),
    .interval_next   (interval_next),
    .trig            (trig)
  );

  assign ev = (st_next.state != st.state) || trig;

  // config registers and link state; a config write reinitializes state
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval   <= INTERVAL_WIDTH'(1000);
      max_interval   <= INTERVAL_WIDTH'(30000);
      repair_limit   <= 16'd3;
      drop_allowance <= 16'd0;
      st             <= STATE_INIT;
      cur_interval   <= INTERVAL_WIDTH'(1000);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MIN_INTERVAL:   min_interval   <= cfg_data;
        CFG_MAX_INTERVAL:   max_interval   <= cfg_data;
        CFG_REPAIR_LIMIT:   repair_limit   <= cfg_data[15:0];
        CFG_DROP_ALLOWANCE: drop_allowance <= cfg_data[15:0];
        default:            drop_allowance <= drop_allowance;
      endcase
      st           <= STATE_INIT;
      cur_interval <= (cfg_index == CFG_MIN_INTERVAL) ? cfg_data : min_interval;
    end else if (s1_fire) begin
      st           <= st_next;
      cur_interval <= interval_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      link_state     <= st_next.state;
      repair_trigger <= trig;
      dead_probes    <= st_next.dead;
      next_interval  <= interval_next;
      event_valid    <= ev;
      event_from     <= ev ? st.state : 3'd0;
      event_to       <= ev ? st_next.state : 3'd0;
      event_time     <= ev ? s1_time : 48'd0;
    end
  end

`ifndef SYNTHESIS
  a_latch_not_connected: assert property (@(posedge clk) disable iff (rst)
    st.latched |-> st.state != LS_CONNECTED)
    else $error("repair latch set while connected");

  a_run_only_connected: assert property (@(posedge clk) disable iff (rst)
    (st.stable_run != 2'd0) |-> st.state == LS_CONNECTED)
    else $error("stable run counted outside connected state");

  a_trigger_not_connected: assert property (@(posedge clk) disable iff (rst)
    (out_valid && repair_trigger) |-> (link_state != LS_CONNECTED) && event_valid)
    else $error("repair trigger on connected probe or without event");

  a_event_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !event_valid) |-> (event_from == 3'd0) && (event_to == 3'd0)
                                    && (event_time == 48'd0))
    else $error("event fields not cleared without event");
`endif

endmodule

`default_nettype wire
